// ===== hdl/exception_entry_and_skip_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Exception entry and skip unit: assertion macros
// Clocked, reset-qualified property wrappers used by the asserting module.
// ----------------------------------------------------------------------------
`ifndef EXCEPTION_ENTRY_AND_SKIP_UNIT_MACROS_SVH
`define EXCEPTION_ENTRY_AND_SKIP_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EESU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define EESU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/eesu_pkg.sv =====
// ----------------------------------------------------------------------------
// Exception entry and skip unit: package
// Shared types, register indexes, event and target codes, status constants.
// ----------------------------------------------------------------------------
package eesu_pkg;

    // Configuration register indexes (byte address is 4 * index)
    localparam int unsigned CFG_ADDR_W = 5;
    localparam logic [2:0] CFG_HIGH_VECTORS   = 3'd0;
    localparam logic [2:0] CFG_VECTOR_BASE    = 3'd1;
    localparam logic [2:0] CFG_THUMB_EXC      = 3'd2;
    localparam logic [2:0] CFG_BIG_ENDIAN_EXC = 3'd3;
    localparam logic [2:0] CFG_LONG_DESC      = 3'd4;

    // Event codes
    localparam logic [1:0] EV_SKIP  = 2'd0;
    localparam logic [1:0] EV_UNDEF = 2'd1;
    localparam logic [1:0] EV_DABT  = 2'd2;
    localparam logic [1:0] EV_PABT  = 2'd3;

    // Banked register targets
    localparam logic [1:0] BANK_NONE = 2'd0;
    localparam logic [1:0] BANK_UND  = 2'd1;
    localparam logic [1:0] BANK_ABT  = 2'd2;

    // Fault register targets
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_DATA  = 2'd1;
    localparam logic [1:0] FAULT_INSTR = 2'd2;

    // Status word constants
    localparam logic [4:0]  MODE_UND  = 5'h1b;
    localparam logic [4:0]  MODE_ABT  = 5'h17;
    localparam logic [31:0] HIGH_BASE = 32'hffff_0000;
    localparam logic [9:0]  FS_LONG   = 10'h222;
    localparam logic [9:0]  FS_SHORT  = 10'h002;

    // Vector offsets
    localparam logic [31:0] VEC_UNDEF = 32'd4;
    localparam logic [31:0] VEC_PABT  = 32'd12;
    localparam logic [31:0] VEC_DABT  = 32'd16;

    typedef struct packed {
        logic        high_vectors;
        logic [31:0] vector_base;
        logic        thumb_exceptions;
        logic        big_endian_exceptions;
        logic        long_descriptor_format;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] status_in;
        logic [31:0] pc_in;
        logic        wide_instruction;
        logic [31:0] fault_address;
    } t_item;

    typedef struct packed {
        logic [31:0] status_out;
        logic [31:0] pc_out;
        logic [1:0]  bank_target;
        logic [31:0] link_value;
        logic [31:0] saved_status;
        logic [1:0]  fault_target;
        logic [31:0] fault_address_out;
        logic [9:0]  fault_status_out;
        logic        it_state_error;
    } t_result;

endpackage

// ===== hdl/exception_entry_and_skip_unit.sv =====
// ----------------------------------------------------------------------------
// Exception entry and skip unit: input register, then result register to o_valid.
// Throughput one event per cycle: busy stays low, input and result regs pipeline.
// Synchronous active-low reset clears the stage valids and config registers.
// ----------------------------------------------------------------------------
`include "exception_entry_and_skip_unit_macros.svh"

module exception_entry_and_skip_unit
    import eesu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_mode,
    input  logic [31:0]           i_status_in,
    input  logic [31:0]           i_pc_in,
    input  logic                  i_wide_instruction,
    input  logic [31:0]           i_fault_address,
    // result channel, one strobed beat per event, no back-pressure
    output logic                  o_valid,
    output logic [31:0]           o_status_out,
    output logic [31:0]           o_pc_out,
    output logic [1:0]            o_bank_target,
    output logic [31:0]           o_link_value,
    output logic [31:0]           o_saved_status,
    output logic [1:0]            o_fault_target,
    output logic [31:0]           o_fault_address_out,
    output logic [9:0]            o_fault_status_out,
    output logic                  o_it_state_error,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg    w_cfg;
    t_item   r_item;
    logic    r_item_valid;
    t_result w_result;
    t_result r_result;
    logic    r_result_valid;
    logic    w_accept;

    // No state carries between events and the receiver never stalls, so the
    // unit is always ready for the next beat.
    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    eesu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input register: capture the beat on accept; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else begin
            r_item_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= '{mode:             i_mode,
                        status_in:        i_status_in,
                        pc_in:            i_pc_in,
                        wide_instruction: i_wide_instruction,
                        fault_address:    i_fault_address};
        end
    end

    // Single pass of bit manipulation and at most one add per output field.
    eesu_calc u_calc (
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Result register: hold each result for exactly one strobed cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= r_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_item_valid) begin
            r_result <= w_result;
        end
    end

    assign o_valid             = r_result_valid;
    assign o_status_out        = r_result.status_out;
    assign o_pc_out            = r_result.pc_out;
    assign o_bank_target       = r_result.bank_target;
    assign o_link_value        = r_result.link_value;
    assign o_saved_status      = r_result.saved_status;
    assign o_fault_target      = r_result.fault_target;
    assign o_fault_address_out = r_result.fault_address_out;
    assign o_fault_status_out  = r_result.fault_status_out;
    assign o_it_state_error    = r_result.it_state_error;

    // Every accepted beat gives a strobe once it has passed the input and result registers.
    `EESU_ASSERT_NEXT(a_accept_to_valid, w_accept, ##1 o_valid, "accepted beat lost")
    // A fault report only comes with abort entry.
    `EESU_ASSERT_SAME(a_fault_only_on_abort, o_valid && (o_fault_target != FAULT_NONE), o_bank_target == BANK_ABT, "fault target without abort bank")
    // Abort entry always writes a fault register.
    `EESU_ASSERT_SAME(a_abort_has_fault, o_valid && (o_bank_target == BANK_ABT), o_fault_target != FAULT_NONE, "abort bank without fault target")
    // IT state error is a skip-only report.
    `EESU_ASSERT_SAME(a_it_error_on_skip, o_valid && o_it_state_error, o_bank_target == BANK_NONE, "IT state error on exception entry")

endmodule

// ===== hdl/eesu_cfg.sv =====
// ----------------------------------------------------------------------------
// Exception entry and skip unit: configuration registers
// APB-style register bank holding vector and exception control bits.
// ----------------------------------------------------------------------------
module eesu_cfg
    import eesu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] w_index;
    logic       w_write;

    assign w_index = paddr[CFG_ADDR_W-1:2];
    assign w_write = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            case (w_index)
                CFG_HIGH_VECTORS:   n_cfg.high_vectors           = pwdata[0];
                CFG_VECTOR_BASE:    n_cfg.vector_base            = pwdata;
                CFG_THUMB_EXC:      n_cfg.thumb_exceptions       = pwdata[0];
                CFG_BIG_ENDIAN_EXC: n_cfg.big_endian_exceptions  = pwdata[0];
                CFG_LONG_DESC:      n_cfg.long_descriptor_format = pwdata[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_index)
            CFG_HIGH_VECTORS:   prdata = {31'd0, r_cfg.high_vectors};
            CFG_VECTOR_BASE:    prdata = r_cfg.vector_base;
            CFG_THUMB_EXC:      prdata = {31'd0, r_cfg.thumb_exceptions};
            CFG_BIG_ENDIAN_EXC: prdata = {31'd0, r_cfg.big_endian_exceptions};
            CFG_LONG_DESC:      prdata = {31'd0, r_cfg.long_descriptor_format};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/eesu_calc.sv =====
// ----------------------------------------------------------------------------
// Exception entry and skip unit: event datapath
// Skip with IT advance, or exception entry status, vector and bank values.
// ----------------------------------------------------------------------------
module eesu_calc
    import eesu_pkg::*;
(
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic        w_thumb;
    logic        w_it_nz;
    logic [2:0]  w_cond;
    logic [4:0]  w_low5;
    logic [31:0] w_skip_status;
    logic [31:0] w_entry_status;
    logic [31:0] w_vec_base;
    logic        w_abort;
    logic [31:0] s;

    assign s       = i_item.status_in;
    assign w_thumb = s[5];
    assign w_it_nz = (|s[15:10]) | (|s[26:25]);
    assign w_abort = (i_item.mode == EV_DABT) || (i_item.mode == EV_PABT);

    // IT advance: shift the low five mask bits, drop the block when it ends
    always_comb begin
        w_cond = s[15:13];
        w_low5 = {s[12:10], s[26:25]};
        if (w_low5[2:0] == 3'd0) begin
            w_cond = 3'd0;
            w_low5 = 5'd0;
        end else begin
            w_low5 = {w_low5[3:0], 1'b0};
        end
        w_skip_status = s;
        if (w_it_nz) begin
            w_skip_status[15:13] = w_cond;
            w_skip_status[12:10] = w_low5[4:2];
            w_skip_status[26:25] = w_low5[1:0];
        end
    end

    // Entry status: new mode, mask I (and A on aborts), clear IT/J, T/E from config
    always_comb begin
        w_entry_status        = s;
        w_entry_status[4:0]   = w_abort ? MODE_ABT : MODE_UND;
        w_entry_status[7]     = 1'b1;
        w_entry_status[8]     = s[8] | w_abort;
        w_entry_status[15:10] = 6'd0;
        w_entry_status[26:25] = 2'd0;
        w_entry_status[24]    = 1'b0;
        w_entry_status[9]     = i_cfg.big_endian_exceptions;
        w_entry_status[5]     = i_cfg.thumb_exceptions;
    end

    assign w_vec_base = i_cfg.high_vectors ? HIGH_BASE : i_cfg.vector_base;

    always_comb begin
        o_result = '0;
        case (i_item.mode)
            EV_SKIP: begin
                o_result.status_out     = w_skip_status;
                o_result.pc_out         = i_item.pc_in
                    + ((w_thumb && !i_item.wide_instruction) ? 32'd2 : 32'd4);
                o_result.it_state_error = !w_thumb && w_it_nz;
            end
            EV_UNDEF: begin
                o_result.status_out   = w_entry_status;
                o_result.pc_out       = w_vec_base + VEC_UNDEF;
                o_result.bank_target  = BANK_UND;
                o_result.link_value   = i_item.pc_in + (w_thumb ? 32'd2 : 32'd4);
                o_result.saved_status = s;
            end
            EV_DABT: begin
                o_result.status_out        = w_entry_status;
                o_result.pc_out            = w_vec_base + VEC_DABT;
                o_result.bank_target       = BANK_ABT;
                o_result.link_value        = i_item.pc_in + 32'd8;
                o_result.saved_status      = s;
                o_result.fault_target      = FAULT_DATA;
                o_result.fault_address_out = i_item.fault_address;
                o_result.fault_status_out  =
                    i_cfg.long_descriptor_format ? FS_LONG : FS_SHORT;
            end
            EV_PABT: begin
                o_result.status_out        = w_entry_status;
                o_result.pc_out            = w_vec_base + VEC_PABT;
                o_result.bank_target       = BANK_ABT;
                o_result.link_value        = i_item.pc_in + 32'd4;
                o_result.saved_status      = s;
                o_result.fault_target      = FAULT_INSTR;
                o_result.fault_address_out = i_item.fault_address;
                o_result.fault_status_out  =
                    i_cfg.long_descriptor_format ? FS_LONG : FS_SHORT;
            end
            default: o_result = '0;
        endcase
    end

endmodule

// ===== dv/tb_exception_entry_and_skip_unit.sv =====
// ----------------------------------------------------------------------------
// Exception entry and skip unit: self-checking testbench
// Drives skip, undefined and abort events through the command port under
// several vector and control settings, predicts each result beat from its own
// model of the status, PC, bank and fault outputs, and compares field by field.
// ----------------------------------------------------------------------------
module tb_exception_entry_and_skip_unit
    import eesu_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam time         CLK_PERIOD     = 8ns;
    localparam int unsigned MAX_GAP        = 64;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned PHASE_EVENTS   = 130;
    localparam int unsigned NUM_PHASES     = 5;
    localparam int unsigned TAIL_CYCLES    = 4;

    // Status word bit positions and the IT field (IT[7:2] at [15:10], IT[1:0] at [26:25])
    localparam int          ST_T    = 5;
    localparam int          ST_I    = 7;
    localparam int          ST_A    = 8;
    localparam int          ST_E    = 9;
    localparam int          ST_J    = 24;
    localparam logic [31:0] IT_MASK = 32'h0600_fc00;

    // ------------------------------------------------------------------------
    // Predictor and store of expected result beats
    // ------------------------------------------------------------------------
    class exc_scoreboard;
        t_cfg        cfg;
        t_result     pending_q[$];
        int unsigned fail_count;

        function new();
            cfg        = '0;
            fail_count = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                CFG_HIGH_VECTORS:   cfg.high_vectors           = value[0];
                CFG_VECTOR_BASE:    cfg.vector_base            = value;
                CFG_THUMB_EXC:      cfg.thumb_exceptions       = value[0];
                CFG_BIG_ENDIAN_EXC: cfg.big_endian_exceptions  = value[0];
                CFG_LONG_DESC:      cfg.long_descriptor_format = value[0];
                default: ;
            endcase
        endfunction

        // Advance the IT state by one instruction; an empty state stays put
        function logic [31:0] next_it(logic [31:0] s);
            logic [2:0] cond;
            logic [4:0] low5;
            if ((s & IT_MASK) == 32'd0)
                return s;
            cond = s[15:13];
            low5 = {s[12:10], s[26:25]};
            if (low5[2:0] == 3'd0) begin
                cond = 3'd0;
                low5 = 5'd0;
            end else begin
                low5 = {low5[3:0], 1'b0};
            end
            s        = s & ~IT_MASK;
            s[15:13] = cond;
            s[12:10] = low5[4:2];
            s[26:25] = low5[1:0];
            return s;
        endfunction

        function logic [31:0] entered_status(logic [31:0] s, logic [4:0] new_mode,
                                             logic [31:0] masks);
            logic [31:0] r;
            r       = {s[31:5], new_mode} | masks;
            r       = r & ~(IT_MASK | (32'd1 << ST_J) | (32'd1 << ST_E) | (32'd1 << ST_T));
            r[ST_T] = cfg.thumb_exceptions;
            r[ST_E] = cfg.big_endian_exceptions;
            return r;
        endfunction

        function void note_event(t_item it);
            t_result     r;
            logic        thumb;
            logic        pabt;
            logic [31:0] base;
            r     = '0;
            thumb = it.status_in[ST_T];
            pabt  = (it.mode == EV_PABT);
            base  = cfg.high_vectors ? HIGH_BASE : cfg.vector_base;
            case (it.mode)
                EV_SKIP: begin
                    r.pc_out = it.pc_in + ((thumb && !it.wide_instruction) ? 32'd2 : 32'd4);
                    r.it_state_error = !thumb && ((it.status_in & IT_MASK) != 32'd0);
                    r.status_out     = next_it(it.status_in);
                end
                EV_UNDEF: begin
                    r.status_out   = entered_status(it.status_in, MODE_UND, 32'd1 << ST_I);
                    r.pc_out       = base + VEC_UNDEF;
                    r.bank_target  = BANK_UND;
                    r.link_value   = it.pc_in + (thumb ? 32'd2 : 32'd4);
                    r.saved_status = it.status_in;
                end
                default: begin
                    r.status_out = entered_status(it.status_in, MODE_ABT,
                                                  (32'd1 << ST_I) | (32'd1 << ST_A));
                    r.pc_out            = base + (pabt ? VEC_PABT : VEC_DABT);
                    r.bank_target       = BANK_ABT;
                    r.link_value        = it.pc_in + (pabt ? 32'd4 : 32'd8);
                    r.saved_status      = it.status_in;
                    r.fault_target      = pabt ? FAULT_INSTR : FAULT_DATA;
                    r.fault_address_out = it.fault_address;
                    r.fault_status_out  = cfg.long_descriptor_format ? FS_LONG : FS_SHORT;
                end
            endcase
            pending_q.push_back(r);
        endfunction

        function void field_cmp(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_q.size() == 0) begin
                $display("%0t: result beat with nothing expected: status %h, pc %h",
                         $time, got.status_out, got.pc_out);
                fail_count++;
                return;
            end
            want = pending_q.pop_front();
            field_cmp("status_out", want.status_out, got.status_out);
            field_cmp("pc_out", want.pc_out, got.pc_out);
            field_cmp("bank_target", 32'(want.bank_target), 32'(got.bank_target));
            field_cmp("link_value", want.link_value, got.link_value);
            field_cmp("saved_status", want.saved_status, got.saved_status);
            field_cmp("fault_target", 32'(want.fault_target), 32'(got.fault_target));
            field_cmp("fault_address_out", want.fault_address_out, got.fault_address_out);
            field_cmp("fault_status_out", 32'(want.fault_status_out),
                      32'(got.fault_status_out));
            field_cmp("it_state_error", 32'(want.it_state_error), 32'(got.it_state_error));
        endfunction

        function int unsigned outstanding();
            return pending_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------------
    logic                  i_clk              = 1'b0;
    logic                  i_rst_n            = 1'b0;
    logic                  start              = 1'b0;
    logic [1:0]            i_mode             = EV_SKIP;
    logic [31:0]           i_status_in        = '0;
    logic [31:0]           i_pc_in            = '0;
    logic                  i_wide_instruction = 1'b0;
    logic [31:0]           i_fault_address    = '0;
    logic                  psel               = 1'b0;
    logic                  penable            = 1'b0;
    logic                  pwrite             = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr              = '0;
    logic [31:0]           pwdata             = '0;

    logic        busy;
    logic        o_valid;
    logic [31:0] o_status_out;
    logic [31:0] o_pc_out;
    logic [1:0]  o_bank_target;
    logic [31:0] o_link_value;
    logic [31:0] o_saved_status;
    logic [1:0]  o_fault_target;
    logic [31:0] o_fault_address_out;
    logic [9:0]  o_fault_status_out;
    logic        o_it_state_error;
    logic [31:0] prdata;
    logic        pready;

    exc_scoreboard sb = new();
    int unsigned   quiet_cycles = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    exception_entry_and_skip_unit i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_mode              (i_mode),
        .i_status_in         (i_status_in),
        .i_pc_in             (i_pc_in),
        .i_wide_instruction  (i_wide_instruction),
        .i_fault_address     (i_fault_address),
        .o_valid             (o_valid),
        .o_status_out        (o_status_out),
        .o_pc_out            (o_pc_out),
        .o_bank_target       (o_bank_target),
        .o_link_value        (o_link_value),
        .o_saved_status      (o_saved_status),
        .o_fault_target      (o_fault_target),
        .o_fault_address_out (o_fault_address_out),
        .o_fault_status_out  (o_fault_status_out),
        .o_it_state_error    (o_it_state_error),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // ------------------------------------------------------------------------
    // Monitor: every signal read here holds its pre-edge value, so the
    // register write, the input beat and the result beat seen at an edge are
    // exactly the ones the block acts on at that edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_item   taken;
        t_result seen;
        if (i_rst_n) begin
            // Mirror register writes into the predictor's configuration
            if (psel && penable && pwrite && pready)
                sb.set_reg(paddr[4:2], pwdata);
            if (start && !busy) begin
                taken.mode             = i_mode;
                taken.status_in        = i_status_in;
                taken.pc_in            = i_pc_in;
                taken.wide_instruction = i_wide_instruction;
                taken.fault_address    = i_fault_address;
                sb.note_event(taken);
            end
            if (o_valid) begin
                seen.status_out        = o_status_out;
                seen.pc_out            = o_pc_out;
                seen.bank_target       = o_bank_target;
                seen.link_value        = o_link_value;
                seen.saved_status      = o_saved_status;
                seen.fault_target      = o_fault_target;
                seen.fault_address_out = o_fault_address_out;
                seen.fault_status_out  = o_fault_status_out;
                seen.it_state_error    = o_it_state_error;
                sb.check_result(seen);
            end
        end
    end

    // Watchdog: end the run once nothing has moved on any port for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable && pready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d beats still expected", $time,
                     sb.outstanding());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Setup then access phase; psel stays high so back-to-back writes never
    // lower and raise it in the same step. The caller releases the bus.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic program_config(input t_cfg c);
        write_reg(CFG_HIGH_VECTORS, {31'd0, c.high_vectors});
        write_reg(CFG_VECTOR_BASE, c.vector_base);
        write_reg(CFG_THUMB_EXC, {31'd0, c.thumb_exceptions});
        write_reg(CFG_BIG_ENDIAN_EXC, {31'd0, c.big_endian_exceptions});
        write_reg(CFG_LONG_DESC, {31'd0, c.long_descriptor_format});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold start low until every expected beat has been checked. Sample on
    // the falling edge so the monitor's work at the rising edge is complete.
    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (sb.outstanding() != 0);
        @(posedge i_clk);
    endtask

    // Idle for a random gap, then present one beat and hold it until taken
    task automatic send_event(input t_item it, input int unsigned idle_pct);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start              <= 1'b1;
        i_mode             <= it.mode;
        i_status_in        <= it.status_in;
        i_pc_in            <= it.pc_in;
        i_wide_instruction <= it.wide_instruction;
        i_fault_address    <= it.fault_address;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic t_item make_event(logic [1:0] mode, logic [31:0] status,
                                         logic [31:0] pc, logic wide, logic [31:0] faddr);
        t_item it;
        it.mode             = mode;
        it.status_in        = status;
        it.pc_in            = pc;
        it.wide_instruction = wide;
        it.fault_address    = faddr;
        return it;
    endfunction

    // Random event: the IT field is mostly left live so the advance logic is
    // exercised, sometimes emptied, sometimes set up to close the block.
    function automatic t_item random_event();
        t_item it;
        it = make_event(2'($urandom_range(3)), $urandom, $urandom,
                        1'($urandom_range(1)), $urandom);
        case ($urandom_range(3))
            0: it.status_in = it.status_in & ~IT_MASK;
            1: begin
                it.status_in[10]    = 1'b0;
                it.status_in[26:25] = 2'b00;
            end
            default: ;
        endcase
        // Push the PC next to the top of the address space now and then
        if ($urandom_range(15) == 0)
            it.pc_in = 32'hffff_fff0 | 32'($urandom_range(15));
        return it;
    endfunction

    function automatic t_cfg phase_config(int unsigned phase);
        t_cfg c;
        c.high_vectors           = 1'($urandom_range(1));
        c.vector_base            = $urandom;
        c.thumb_exceptions       = 1'($urandom_range(1));
        c.big_endian_exceptions  = 1'($urandom_range(1));
        c.long_descriptor_format = 1'($urandom_range(1));
        case (phase)
            0: c = '0;
            1: c = '1;
            2: begin
                // Low vectors at the very top: the vector offset wraps
                c.high_vectors           = 1'b0;
                c.vector_base            = 32'hffff_ffff;
                c.thumb_exceptions       = 1'b1;
                c.big_endian_exceptions  = 1'b0;
                c.long_descriptor_format = 1'b1;
            end
            3: c.high_vectors = 1'b0;
            default: c.high_vectors = 1'b1;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned idle_pct [NUM_PHASES];
        t_item       directed_q[$];

        idle_pct = '{0, 81, 32, 0, 81};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_config(phase_config(0));

        // Directed: widths of skipped instruction, IT advance and closing,
        // IT bits in ARM state, PC wrap, both states on entry, field extremes
        directed_q.push_back(make_event(EV_SKIP, 32'h0000_0000, 32'h0000_0000, 1'b0, '0));
        directed_q.push_back(make_event(EV_SKIP, 32'h0000_0020, 32'h0000_1000, 1'b0, '0));
        directed_q.push_back(make_event(EV_SKIP, 32'h0000_0020, 32'h0000_1000, 1'b1, '0));
        directed_q.push_back(make_event(EV_SKIP, 32'h0000_8c20, 32'h0000_2000, 1'b0, '0));
        directed_q.push_back(make_event(EV_SKIP, 32'h0000_a820, 32'h0000_2002, 1'b0, '0));
        directed_q.push_back(make_event(EV_SKIP, 32'h0600_0020, 32'h0000_2004, 1'b1, '0));
        directed_q.push_back(make_event(EV_SKIP, 32'h0600_0000, 32'h0000_3000, 1'b0, '0));
        directed_q.push_back(make_event(EV_SKIP, 32'hffff_ffdf, 32'h0000_3004, 1'b0, '0));
        directed_q.push_back(make_event(EV_SKIP, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '1));
        directed_q.push_back(make_event(EV_SKIP, 32'hffff_ffff, 32'hffff_fffe, 1'b1, '1));
        directed_q.push_back(make_event(EV_SKIP, 32'h0000_0000, 32'hffff_fffc, 1'b1, '0));
        directed_q.push_back(make_event(EV_UNDEF, 32'h0000_0010, 32'h0000_8000, 1'b0, '0));
        directed_q.push_back(make_event(EV_UNDEF, 32'h0000_0030, 32'hffff_ffff, 1'b1, '1));
        directed_q.push_back(make_event(EV_UNDEF, 32'hffff_ffff, 32'hffff_fffc, 1'b0, '1));
        directed_q.push_back(make_event(EV_DABT, 32'h0000_0000, 32'hffff_fffc, 1'b0, '0));
        directed_q.push_back(make_event(EV_DABT, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '1));
        directed_q.push_back(make_event(EV_DABT, 32'h0000_0020, 32'h0000_4000, 1'b1,
                                        32'h8000_0001));
        directed_q.push_back(make_event(EV_PABT, 32'h0000_0013, 32'h0000_0000, 1'b0,
                                        32'h1234_5678));
        directed_q.push_back(make_event(EV_PABT, 32'hffff_ffff, 32'hffff_fffe, 1'b1, '1));
        foreach (directed_q[k])
            send_event(directed_q[k], 0);
        drain_results();

        // Random phases, each under its own register setting
        for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0)
                program_config(phase_config(phase));
            for (int unsigned n = 0; n < PHASE_EVENTS; n++) begin
                // Pause now and then until the pipeline has emptied
                if (n == 10 || $urandom_range(39) == 0)
                    drain_results();
                send_event(random_event(), idle_pct[phase]);
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
